// ===== sv/sequenced_byte_trace_ring_core_macros.svh =====
// Assertion macros used by the trace ring core RTL.
`ifndef SEQUENCED_BYTE_TRACE_RING_CORE_MACROS_SVH
`define SEQUENCED_BYTE_TRACE_RING_CORE_MACROS_SVH

// same-cycle implication, masked while in reset
`define SBTR_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("sbtr: assertion failed");

// next-cycle implication, masked while in reset
`define SBTR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("sbtr: assertion failed");

`endif

// ===== sv/sbtr_pkg.sv =====
// Shared constants for the sequenced byte trace ring.
package sbtr_pkg;

    localparam int DEF_RING_DEPTH = 4096;
    localparam int DEF_MAX_READ   = 64;

    localparam int DATA_W  = 8;
    localparam int SEQ_W   = 64;
    localparam int COUNT_W = 7;

    // slave tdata: data_byte, read_start, read_count
    localparam int S_BYTE_LO  = 0;
    localparam int S_START_LO = S_BYTE_LO + DATA_W;
    localparam int S_COUNT_LO = S_START_LO + SEQ_W;
    localparam int S_TDATA_W  = ((S_COUNT_LO + COUNT_W + 7) / 8) * 8;

    // master tdata: out_byte, byte_position, write_position, oldest_position
    localparam int M_TDATA_W  = ((DATA_W + 3 * SEQ_W + 7) / 8) * 8;

    localparam logic KIND_APPEND = 1'b0;
    localparam logic KIND_READ   = 1'b1;

endpackage

// ===== sv/sequenced_byte_trace_ring_core.sv =====
// Top level of the sequenced byte trace ring: sequencer, output pipeline, byte store.
//
// Slave stream: tuser selects the kind (0 append, 1 read), tlast marks the end of
// a pushed message and has no effect. An append stores one byte and produces no
// output; appends are taken one per cycle while no read is busy. A read names a
// start sequence and a count; its start is raised to the oldest byte held and its
// count clipped to the bytes available and to MAX_READ.
// Master stream: one transfer per byte read, in order, tlast on the last one; a
// read with nothing to return yields one transfer with tuser set. Every transfer
// carries the write and oldest positions seen by its read.
// A read passes through the CLAMP, MEASURE and CLIP states before its results are
// read from the store; the slave side stays busy for the whole read, through the
// 64-bit start/limit compare and one store read per byte (the EMPTY state if none).
// Results stream one per cycle through a registered store read and an output
// register; when the master stalls, the store read data holds and the sequencer
// waits, so nothing is lost. Appends may be taken while old results still wait.
// Reset clears the sequence and control state; the byte store is not cleared and
// needs no pass, since a read can only reach bytes already written.
module sequenced_byte_trace_ring_core #(
    parameter int RING_DEPTH = sbtr_pkg::DEF_RING_DEPTH,
    parameter int MAX_READ   = sbtr_pkg::DEF_MAX_READ
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // data_byte[7:0], read_start[71:8], read_count[78:72], zero fill
    input  logic [sbtr_pkg::S_TDATA_W-1:0] s_tdata,
    // kind
    input  logic                           s_tuser,
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // out_byte[7:0], byte_position[71:8], write_position[135:72],
    // oldest_position[199:136]
    output logic [sbtr_pkg::M_TDATA_W-1:0] m_tdata,
    // none_available
    output logic                           m_tuser,
    output logic                           m_tlast
);

`include "sequenced_byte_trace_ring_core_macros.svh"

    localparam int AW = $clog2(RING_DEPTH);
    localparam int LW = AW + 1;
    localparam int CW = $clog2(MAX_READ + 1);
    localparam int XW = (LW > CW) ? LW : CW;
    localparam int SW = sbtr_pkg::SEQ_W;
    localparam int DW = sbtr_pkg::DATA_W;

    typedef enum logic [2:0] {
        ST_IDLE, ST_CLAMP, ST_MEASURE, ST_CLIP, ST_RUN, ST_EMPTY
    } state_t;

    state_t          state_reg;
    logic [SW-1:0]   ws_reg;
    logic [SW-1:0]   oldest_reg;
    logic [AW-1:0]   wr_slot_reg;

    logic [SW-1:0]   start_reg;
    logic [CW-1:0]   cnt_reg;
    logic [LW-1:0]   avail_reg;
    logic            empty_reg;
    logic [AW-1:0]   rd_slot_reg;
    logic [SW-1:0]   snap_ws_reg;
    logic [SW-1:0]   snap_old_reg;

    logic            p1_valid_reg;
    logic [SW-1:0]   p1_pos_reg;
    logic [SW-1:0]   p1_ws_reg;
    logic [SW-1:0]   p1_old_reg;
    logic            p1_none_reg;
    logic            p1_last_reg;

    logic            m_valid_reg;
    logic [DW-1:0]   m_byte_reg;
    logic [SW-1:0]   m_pos_reg;
    logic [SW-1:0]   m_ws_reg;
    logic [SW-1:0]   m_old_reg;
    logic            m_none_reg;
    logic            m_last_reg;

    logic            s_xfer;
    logic            append_xfer;
    logic            read_xfer;
    logic            advance;
    logic            rd_en;
    logic [DW-1:0]   rd_data;
    logic [SW-1:0]   oldest_next;
    logic [sbtr_pkg::COUNT_W-1:0] s_count;
    logic [CW-1:0]   cnt_in;
    logic [CW-1:0]   cnt_clip;
    logic [AW-1:0]   rd_slot_next;
    logic [LW-1:0]   wr_slot_ext;

    assign s_tready    = (state_reg == ST_IDLE);
    assign s_xfer      = s_tvalid && s_tready;
    assign append_xfer = s_xfer && (s_tuser == sbtr_pkg::KIND_APPEND);
    assign read_xfer   = s_xfer && (s_tuser == sbtr_pkg::KIND_READ);
    assign advance     = !m_valid_reg || m_tready;
    assign rd_en       = (state_reg == ST_RUN) && advance;

    assign s_count = s_tdata[sbtr_pkg::S_COUNT_LO +: sbtr_pkg::COUNT_W];
    assign cnt_in  = (s_count > sbtr_pkg::COUNT_W'(MAX_READ)) ? CW'(MAX_READ) : CW'(s_count);

    assign oldest_next = (ws_reg > SW'(RING_DEPTH)) ? (ws_reg - SW'(RING_DEPTH)) : '0;

    assign cnt_clip = (XW'(avail_reg) < XW'(cnt_reg)) ? CW'(avail_reg) : cnt_reg;

    assign wr_slot_ext = {1'b0, wr_slot_reg};
    always_comb begin
        if (wr_slot_ext >= avail_reg) begin
            rd_slot_next = AW'(wr_slot_ext - avail_reg);
        end else begin
            rd_slot_next = AW'(wr_slot_ext + (LW'(RING_DEPTH) - avail_reg));
        end
    end

    sbtr_ram #(
        .WIDTH (DW),
        .DEPTH (RING_DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (append_xfer),
        .wr_addr (wr_slot_reg),
        .wr_data (s_tdata[sbtr_pkg::S_BYTE_LO +: DW]),
        .rd_en   (rd_en),
        .rd_addr (rd_slot_reg),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            ws_reg       <= '0;
            oldest_reg   <= '0;
            wr_slot_reg  <= '0;
            p1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            oldest_reg <= oldest_next;

            if (append_xfer) begin
                ws_reg <= ws_reg + SW'(1);
                if (wr_slot_reg == AW'(RING_DEPTH - 1)) begin
                    wr_slot_reg <= '0;
                end else begin
                    wr_slot_reg <= wr_slot_reg + AW'(1);
                end
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (read_xfer) begin
                        start_reg <= s_tdata[sbtr_pkg::S_START_LO +: SW];
                        cnt_reg   <= cnt_in;
                        state_reg <= ST_CLAMP;
                    end
                end
                ST_CLAMP: begin
                    if (start_reg < oldest_reg) begin
                        start_reg <= oldest_reg;
                    end
                    snap_ws_reg  <= ws_reg;
                    snap_old_reg <= oldest_reg;
                    state_reg    <= ST_MEASURE;
                end
                ST_MEASURE: begin
                    avail_reg <= LW'(ws_reg - start_reg);
                    empty_reg <= (cnt_reg == '0) || (start_reg >= ws_reg);
                    state_reg <= ST_CLIP;
                end
                ST_CLIP: begin
                    cnt_reg     <= cnt_clip;
                    rd_slot_reg <= rd_slot_next;
                    state_reg   <= empty_reg ? ST_EMPTY : ST_RUN;
                end
                ST_RUN: begin
                    if (advance) begin
                        start_reg <= start_reg + SW'(1);
                        cnt_reg   <= cnt_reg - CW'(1);
                        if (rd_slot_reg == AW'(RING_DEPTH - 1)) begin
                            rd_slot_reg <= '0;
                        end else begin
                            rd_slot_reg <= rd_slot_reg + AW'(1);
                        end
                        if (cnt_reg == CW'(1)) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_EMPTY: begin
                    if (advance) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase

            if (advance) begin
                m_valid_reg  <= p1_valid_reg;
                m_byte_reg   <= p1_none_reg ? '0 : rd_data;
                m_pos_reg    <= p1_pos_reg;
                m_ws_reg     <= p1_ws_reg;
                m_old_reg    <= p1_old_reg;
                m_none_reg   <= p1_none_reg;
                m_last_reg   <= p1_last_reg;

                p1_valid_reg <= (state_reg == ST_RUN) || (state_reg == ST_EMPTY);
                p1_pos_reg   <= start_reg;
                p1_ws_reg    <= snap_ws_reg;
                p1_old_reg   <= snap_old_reg;
                p1_none_reg  <= (state_reg == ST_EMPTY);
                p1_last_reg  <= (state_reg == ST_EMPTY) || (cnt_reg == CW'(1));
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = sbtr_pkg::M_TDATA_W'({m_old_reg, m_ws_reg, m_pos_reg, m_byte_reg});
    assign m_tuser  = m_none_reg;
    assign m_tlast  = m_last_reg;

    `SBTR_ASSERT_IMPL(a_stall_holds_read, aclk, aresetn, m_tvalid && !m_tready, !rd_en)
    `SBTR_ASSERT_IMPL(a_run_has_bytes, aclk, aresetn, state_reg == ST_RUN, cnt_reg != '0)
    `SBTR_ASSERT_IMPL(a_empty_is_last, aclk, aresetn, p1_valid_reg && p1_none_reg, p1_last_reg)
    `SBTR_ASSERT_NEXT(a_seq_frozen_in_read, aclk, aresetn, state_reg != ST_IDLE,
                      $stable(ws_reg))

endmodule

// ===== sv/sbtr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module sbtr_ram #(
    parameter int WIDTH = sbtr_pkg::DATA_W,
    parameter int DEPTH = sbtr_pkg::DEF_RING_DEPTH,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
